FILE: sv/tll_pkg.sv
package tll_pkg;

    // token kinds as seen on the result channel
    typedef enum logic [4:0] {
        TK_ILLEGAL   = 5'd0,
        TK_EOF       = 5'd1,
        TK_IDENT     = 5'd2,
        TK_INT       = 5'd3,
        TK_ASSIGN    = 5'd4,
        TK_PLUS      = 5'd5,
        TK_MINUS     = 5'd6,
        TK_BANG      = 5'd7,
        TK_ASTERISK  = 5'd8,
        TK_SLASH     = 5'd9,
        TK_LT        = 5'd10,
        TK_GT        = 5'd11,
        TK_COMMA     = 5'd12,
        TK_SEMICOLON = 5'd13,
        TK_LPAREN    = 5'd14,
        TK_RPAREN    = 5'd15,
        TK_LBRACE    = 5'd16,
        TK_RBRACE    = 5'd17,
        TK_FUNCTION  = 5'd18,
        TK_LET       = 5'd19,
        TK_TRUE      = 5'd20,
        TK_FALSE     = 5'd21,
        TK_IF        = 5'd22,
        TK_ELSE      = 5'd23,
        TK_RETURN    = 5'd24,
        TK_EQ        = 5'd25,
        TK_NOT_EQ    = 5'd26
    } tok_kind_t;

    // class of the token still being collected
    typedef enum logic [2:0] {
        PEND_NONE   = 3'd0,
        PEND_IDENT  = 3'd1,
        PEND_NUMBER = 3'd2,
        PEND_ASSIGN = 3'd3,
        PEND_BANG   = 3'd4
    } pend_t;

    // characters of interest
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_EQ        = 8'h3D;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    // longest keyword; longer identifiers are never keywords
    localparam int KW_CHARS = 6;
    localparam int KW_IDX_W = $clog2(KW_CHARS);
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // most tokens one text byte can cause
    localparam int MAX_TOKENS = 3;
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int SLOT_W = $clog2(MAX_TOKENS);

    typedef logic [KW_CHARS-1:0][7:0] kw_chars_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] start;
        logic [15:0] length;
    } token_t;

    // tokens caused by one text byte
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        token_t [MAX_TOKENS-1:0]         tok;
    } bundle_t;

    // front to queue
    typedef struct packed {
        logic    valid;
        bundle_t data;
    } q_wr_t;

    // queue head to back
    typedef struct packed {
        logic    valid;
        bundle_t data;
    } q_rd_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {[CH_LOWER_A:CH_LOWER_Z], [CH_UPPER_A:CH_UPPER_Z], CH_UNDER});
    endfunction

    function automatic logic is_numeral(input logic [7:0] b);
        return (b inside {[CH_ZERO:CH_NINE]});
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR});
    endfunction

    // kind of a byte that stands on its own; illegal for anything else
    function automatic tok_kind_t single_kind(input logic [7:0] b);
        tok_kind_t k;
        case (b)
            CH_SEMI:   k = TK_SEMICOLON;
            CH_LPAREN: k = TK_LPAREN;
            CH_RPAREN: k = TK_RPAREN;
            CH_COMMA:  k = TK_COMMA;
            CH_PLUS:   k = TK_PLUS;
            CH_MINUS:  k = TK_MINUS;
            CH_STAR:   k = TK_ASTERISK;
            CH_SLASH:  k = TK_SLASH;
            CH_LT:     k = TK_LT;
            CH_GT:     k = TK_GT;
            CH_LBRACE: k = TK_LBRACE;
            CH_RBRACE: k = TK_RBRACE;
            default:   k = TK_ILLEGAL;
        endcase
        return k;
    endfunction

    // keyword lookup on the stored leading characters
    function automatic tok_kind_t kw_kind(input kw_chars_t c, input logic [15:0] len);
        tok_kind_t k;
        k = TK_IDENT;
        case (len)
            16'd2:
            begin
                if ({c[0], c[1]} == "fn")
                    k = TK_FUNCTION;
                else if ({c[0], c[1]} == "if")
                    k = TK_IF;
            end
            16'd3:
            begin
                if ({c[0], c[1], c[2]} == "let")
                    k = TK_LET;
            end
            16'd4:
            begin
                if ({c[0], c[1], c[2], c[3]} == "true")
                    k = TK_TRUE;
                else if ({c[0], c[1], c[2], c[3]} == "else")
                    k = TK_ELSE;
            end
            16'd5:
            begin
                if ({c[0], c[1], c[2], c[3], c[4]} == "false")
                    k = TK_FALSE;
            end
            16'd6:
            begin
                if ({c[0], c[1], c[2], c[3], c[4], c[5]} == "return")
                    k = TK_RETURN;
            end
            default: k = TK_IDENT;
        endcase
        return k;
    endfunction

    // token that a pending class turns into when it is closed
    function automatic token_t pend_token(input pend_t pc, input logic [15:0] start,
                                          input logic [15:0] len, input kw_chars_t c);
        token_t t;
        t.start  = start;
        t.length = len;
        case (pc)
            PEND_IDENT:  t.kind = kw_kind(c, len);
            PEND_NUMBER: t.kind = TK_INT;
            PEND_ASSIGN:
            begin
                t.kind   = TK_ASSIGN;
                t.length = 16'd1;
            end
            PEND_BANG:
            begin
                t.kind   = TK_BANG;
                t.length = 16'd1;
            end
            default: t.kind = TK_ILLEGAL;
        endcase
        return t;
    endfunction

endpackage

FILE: sv/tll_ifs.sv
interface tll_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface tll_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

FILE: sv/tll_front.sv
module tll_front #(
    parameter longint unsigned MAX_INPUT_LEN = 65536
) (
    input  logic            clk,
    input  logic            rst_n,
    tll_byte_if.sink        text,
    input  logic            q_full,
    output tll_pkg::q_wr_t  q_wr
);

    localparam int POS_W = $clog2(MAX_INPUT_LEN);

    tll_pkg::pend_t     pend_reg, pend_next;
    logic [15:0]        begin_reg, begin_next;
    logic [15:0]        len_reg, len_next;
    tll_pkg::kw_chars_t chars_reg, chars_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               fin_reg, fin_next;

    logic               accept;
    logic               live;
    logic [7:0]         b;
    logic [POS_W-1:0]   pos_step;
    logic [15:0]        pos16;
    logic [15:0]        step16;
    logic               b_alpha, b_digit, b_space;
    logic               extend, pair;

    tll_pkg::pend_t     lex_pc;
    logic [15:0]        lex_begin;
    logic [15:0]        lex_len;
    tll_pkg::kw_chars_t lex_chars;

    tll_pkg::bundle_t   bundle;
    logic [tll_pkg::CNT_W-1:0] cnt;

    // a finished text swallows every further beat
    assign text.ready = fin_reg | ~q_full;
    assign accept     = text.valid & text.ready;
    assign live       = accept & ~fin_reg;
    assign b          = text.in_byte;

    assign pos_step = (pos_reg == POS_W'(MAX_INPUT_LEN - 1)) ? '0 : pos_reg + 1'b1;
    assign pos16    = 16'(pos_reg);
    assign step16   = 16'(pos_step);

    assign b_alpha = tll_pkg::is_alpha(b);
    assign b_digit = tll_pkg::is_numeral(b);
    assign b_space = tll_pkg::is_space(b);
    assign extend  = ((pend_reg == tll_pkg::PEND_IDENT) & b_alpha)
                   | ((pend_reg == tll_pkg::PEND_NUMBER) & b_digit);
    assign pair    = ((pend_reg == tll_pkg::PEND_ASSIGN) | (pend_reg == tll_pkg::PEND_BANG))
                   & (b == tll_pkg::CH_EQ);

    // pending token after this byte, before any end-of-text flush
    always_comb
    begin
        lex_pc    = pend_reg;
        lex_begin = begin_reg;
        lex_len   = len_reg;
        lex_chars = chars_reg;
        if (extend)
        begin
            if ((pend_reg == tll_pkg::PEND_IDENT) && (len_reg < 16'(tll_pkg::KW_CHARS)))
                lex_chars[len_reg[tll_pkg::KW_IDX_W-1:0]] = b;
            if (len_reg != tll_pkg::LEN_MAX)
                lex_len = len_reg + 16'd1;
        end
        else
        begin
            lex_pc    = tll_pkg::PEND_NONE;
            lex_begin = pos16;
            lex_len   = 16'd1;
            if (!pair)
            begin
                if (b == tll_pkg::CH_EQ)
                    lex_pc = tll_pkg::PEND_ASSIGN;
                else if (b == tll_pkg::CH_BANG)
                    lex_pc = tll_pkg::PEND_BANG;
                else if (b_alpha)
                begin
                    lex_pc       = tll_pkg::PEND_IDENT;
                    lex_chars[0] = b;
                end
                else if (b_digit)
                    lex_pc = tll_pkg::PEND_NUMBER;
            end
        end
    end

    // next state
    always_comb
    begin
        pend_next  = pend_reg;
        begin_next = begin_reg;
        len_next   = len_reg;
        chars_next = chars_reg;
        pos_next   = pos_reg;
        fin_next   = fin_reg;
        if (live)
        begin
            pos_next = pos_step;
            if (b == tll_pkg::CH_NUL)
            begin
                pend_next = tll_pkg::PEND_NONE;
                fin_next  = 1'b1;
            end
            else
            begin
                pend_next  = text.end_of_input ? tll_pkg::PEND_NONE : lex_pc;
                begin_next = lex_begin;
                len_next   = lex_len;
                chars_next = lex_chars;
                fin_next   = text.end_of_input;
            end
        end
    end

    // tokens caused by this byte
    always_comb
    begin
        bundle = '0;
        cnt    = '0;
        if (b == tll_pkg::CH_NUL)
        begin
            if (pend_reg != tll_pkg::PEND_NONE)
            begin
                bundle.tok[cnt[tll_pkg::SLOT_W-1:0]] =
                    tll_pkg::pend_token(pend_reg, begin_reg, len_reg, chars_reg);
                cnt = cnt + 1'b1;
            end
            bundle.tok[cnt[tll_pkg::SLOT_W-1:0]] = '{tll_pkg::TK_EOF, pos16, 16'd0};
            cnt = cnt + 1'b1;
        end
        else
        begin
            if (pair)
            begin
                bundle.tok[cnt[tll_pkg::SLOT_W-1:0]] =
                    '{(pend_reg == tll_pkg::PEND_ASSIGN) ? tll_pkg::TK_EQ : tll_pkg::TK_NOT_EQ,
                      begin_reg, 16'd2};
                cnt = cnt + 1'b1;
            end
            else if (!extend)
            begin
                if (pend_reg != tll_pkg::PEND_NONE)
                begin
                    bundle.tok[cnt[tll_pkg::SLOT_W-1:0]] =
                        tll_pkg::pend_token(pend_reg, begin_reg, len_reg, chars_reg);
                    cnt = cnt + 1'b1;
                end
                if (!(b_space || b_alpha || b_digit || (b == tll_pkg::CH_EQ)
                      || (b == tll_pkg::CH_BANG)))
                begin
                    bundle.tok[cnt[tll_pkg::SLOT_W-1:0]] =
                        '{tll_pkg::single_kind(b), pos16, 16'd1};
                    cnt = cnt + 1'b1;
                end
            end
            if (text.end_of_input)
            begin
                if (lex_pc != tll_pkg::PEND_NONE)
                begin
                    bundle.tok[cnt[tll_pkg::SLOT_W-1:0]] =
                        tll_pkg::pend_token(lex_pc, lex_begin, lex_len, lex_chars);
                    cnt = cnt + 1'b1;
                end
                bundle.tok[cnt[tll_pkg::SLOT_W-1:0]] = '{tll_pkg::TK_EOF, step16, 16'd0};
                cnt = cnt + 1'b1;
            end
        end
        bundle.count = cnt;
    end

    assign q_wr.valid = live & (cnt != '0);
    assign q_wr.data  = bundle;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= tll_pkg::PEND_NONE;
            begin_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            begin_reg <= begin_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            fin_reg   <= fin_next;
        end
    end

    // keyword characters hold payload only
    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
    end

    // nothing is lexed once the text has ended
    a_quiet_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !q_wr.valid)
        else $error("token pushed after end of text");

    // end of text always leaves nothing pending
    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (live && ((b == tll_pkg::CH_NUL) || text.end_of_input))
        |=> (fin_reg && (pend_reg == tll_pkg::PEND_NONE)))
        else $error("pending token left after end of text");

endmodule

FILE: sv/tll_queue.sv
module tll_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tll_pkg::q_wr_t  q_wr,
    output logic            full,
    output tll_pkg::q_rd_t  q_rd,
    input  logic            pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tll_pkg::bundle_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push, take;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign push  = q_wr.valid & ~full;
    assign take  = pop & (cnt_reg != '0);

    assign q_rd.valid = (cnt_reg != '0);
    assign q_rd.data  = entry_reg[rd_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (take)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !take)
            cnt_next = cnt_reg + 1'b1;
        else if (take && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // bundle storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= q_wr.data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr.valid && full))
        else $error("bundle offered to a full queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

endmodule

FILE: sv/tll_back.sv
module tll_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tll_pkg::q_rd_t  q_rd,
    output logic            pop,
    tll_token_if.source     tokens
);

    logic [tll_pkg::SLOT_W-1:0] slot_reg, slot_next;
    tll_pkg::token_t            cur;
    logic                       last;
    logic                       beat;

    assign cur  = q_rd.data.tok[slot_reg];
    assign last = (tll_pkg::CNT_W'(slot_reg) == q_rd.data.count - 1'b1);
    assign beat = tokens.valid & tokens.ready;
    assign pop  = beat & last;

    assign tokens.valid        = q_rd.valid;
    assign tokens.token_kind   = cur.kind;
    assign tokens.token_start  = cur.start;
    assign tokens.token_length = cur.length;
    assign tokens.last_of_run  = last;

    // walk the tokens of the head bundle
    always_comb
    begin
        slot_next = slot_reg;
        if (beat)
            slot_next = last ? '0 : slot_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    // a bundle never shows past its token count
    a_slot_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd.valid |-> (tll_pkg::CNT_W'(slot_reg) < q_rd.data.count))
        else $error("slot beyond bundle count");

endmodule

FILE: sv/toy_language_lexer.sv
// Streaming lexer for a small scripting language.
// text channel: one source byte a beat (in_byte, end_of_input). A zero byte or
// a beat with end_of_input set closes the text: the pending token is flushed
// and an EOF token follows. Beats after that are taken and dropped until reset.
// tokens channel: one token a beat (token_kind, token_start, token_length,
// last_of_run); last_of_run marks the final token caused by one text byte.
// Throughput: one text byte per cycle while the queue is not full. Each
// accepted byte is classified by the front lexer, and its tokens (zero to
// three) go as one bundle into a QUEUE_DEPTH deep queue; the back end sends
// one token a cycle, so a burst of bytes that each give two or three tokens
// is paced by the token port. Bundles are registered in the queue first.
// Stall: while tokens.ready is low the queue fills; text.ready falls only once
// the queue is full, and no token is lost or repeated.
// Reset (rst_n low, asynchronous): nothing pending, position zero, queue empty.
// Positions count modulo MAX_INPUT_LEN; token lengths saturate at 65535.
module toy_language_lexer #(
    parameter longint unsigned MAX_INPUT_LEN = 65536,
    parameter int              QUEUE_DEPTH   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    tll_byte_if.sink    text,
    tll_token_if.source tokens
);

    tll_pkg::q_wr_t q_wr;
    tll_pkg::q_rd_t q_rd;
    logic           q_full;
    logic           q_pop;

    tll_front #(
        .MAX_INPUT_LEN (MAX_INPUT_LEN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    tll_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .full  (q_full),
        .q_rd  (q_rd),
        .pop   (q_pop)
    );

    tll_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_rd   (q_rd),
        .pop    (q_pop),
        .tokens (tokens)
    );

endmodule

FILE: tb/tb_toy_language_lexer.sv
`timescale 1ns / 1ps

module tb_toy_language_lexer;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 200;
    localparam int LONG_WORD   = 24;

    typedef struct {
        tll_pkg::tok_kind_t kind;
        logic [15:0]        start;
        logic [15:0]        length;
        logic               last;
    } lexed_token_t;

    logic clk;
    logic rst_n;

    tll_byte_if  text_if ();
    tll_token_if tok_if ();

    toy_language_lexer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .tokens (tok_if)
    );

    // keyword spellings and the kinds they turn into
    string              keywords [7] = '{"fn", "let", "true", "false", "if", "else",
                                         "return"};
    tll_pkg::tok_kind_t kw_kinds [7] = '{tll_pkg::TK_FUNCTION, tll_pkg::TK_LET,
                                         tll_pkg::TK_TRUE, tll_pkg::TK_FALSE,
                                         tll_pkg::TK_IF, tll_pkg::TK_ELSE,
                                         tll_pkg::TK_RETURN};
    string     single_ops   = "=!+-*/<>,;(){}";
    string     stall_ops    = "+-*/<>,;(){}";
    string     blanks       = " \t\n\r";

    // lexer state as the testbench sees it
    tll_pkg::pend_t lex_pend  = tll_pkg::PEND_NONE;
    logic [15:0]    lex_begin = '0;
    logic [15:0]    lex_len   = '0;
    logic [7:0]     kw_buf [6];
    logic [15:0]    lex_pos   = '0;
    bit             text_done = 1'b0;

    lexed_token_t byte_tokens [$];
    lexed_token_t tokens_due [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;
    int bytes_sent     = 0;
    int tokens_checked = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;
    int kinds_seen_cnt = 0;
    bit kinds_seen [32];

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    function automatic bit is_word_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit is_dec_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic tll_pkg::tok_kind_t op_kind(input logic [7:0] b);
        case (b)
            "+":     return tll_pkg::TK_PLUS;
            "-":     return tll_pkg::TK_MINUS;
            "*":     return tll_pkg::TK_ASTERISK;
            "/":     return tll_pkg::TK_SLASH;
            "<":     return tll_pkg::TK_LT;
            ">":     return tll_pkg::TK_GT;
            ",":     return tll_pkg::TK_COMMA;
            ";":     return tll_pkg::TK_SEMICOLON;
            "(":     return tll_pkg::TK_LPAREN;
            ")":     return tll_pkg::TK_RPAREN;
            "{":     return tll_pkg::TK_LBRACE;
            "}":     return tll_pkg::TK_RBRACE;
            default: return tll_pkg::TK_ILLEGAL;
        endcase
    endfunction

    function automatic void emit(input tll_pkg::tok_kind_t k, input logic [15:0] s,
                                 input logic [15:0] l);
        lexed_token_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.last   = 1'b0;
        byte_tokens.push_back(t);
    endfunction

    // identifiers up to six characters may spell a keyword
    function automatic tll_pkg::tok_kind_t word_kind();
        tll_pkg::tok_kind_t k;
        bit                 same;
        k = tll_pkg::TK_IDENT;
        if (lex_len <= 6)
        begin
            for (int i = 0; i < 7; i++)
            begin
                if (keywords[i].len() == lex_len)
                begin
                    same = 1'b1;
                    for (int j = 0; j < keywords[i].len(); j++)
                        if (kw_buf[j] != keywords[i][j])
                            same = 1'b0;
                    if (same)
                        k = kw_kinds[i];
                end
            end
        end
        return k;
    endfunction

    // close whatever token is still open
    function automatic void close_pending();
        case (lex_pend)
            tll_pkg::PEND_IDENT:  emit(word_kind(), lex_begin, lex_len);
            tll_pkg::PEND_NUMBER: emit(tll_pkg::TK_INT, lex_begin, lex_len);
            tll_pkg::PEND_ASSIGN: emit(tll_pkg::TK_ASSIGN, lex_begin, 16'd1);
            tll_pkg::PEND_BANG:   emit(tll_pkg::TK_BANG, lex_begin, 16'd1);
            default:              ;
        endcase
        lex_pend = tll_pkg::PEND_NONE;
    endfunction

    // byte with nothing open before it
    function automatic void lex_start(input logic [7:0] b, input logic [15:0] at);
        if (b == " " || b == "\t" || b == "\n" || b == "\r")
            return;
        if (b == "=" || b == "!")
        begin
            lex_pend  = (b == "=") ? tll_pkg::PEND_ASSIGN : tll_pkg::PEND_BANG;
            lex_begin = at;
            lex_len   = 16'd1;
            return;
        end
        if (is_word_char(b))
        begin
            lex_pend  = tll_pkg::PEND_IDENT;
            lex_begin = at;
            lex_len   = 16'd1;
            kw_buf[0] = b;
            return;
        end
        if (is_dec_digit(b))
        begin
            lex_pend  = tll_pkg::PEND_NUMBER;
            lex_begin = at;
            lex_len   = 16'd1;
            return;
        end
        emit(op_kind(b), at, 16'd1);
    endfunction

    function automatic void lex_continue(input logic [7:0] b, input logic [15:0] at);
        if (lex_pend == tll_pkg::PEND_IDENT && is_word_char(b))
        begin
            if (lex_len < 6)
                kw_buf[lex_len[2:0]] = b;
            if (lex_len != 16'hFFFF)
                lex_len++;
            return;
        end
        if (lex_pend == tll_pkg::PEND_NUMBER && is_dec_digit(b))
        begin
            if (lex_len != 16'hFFFF)
                lex_len++;
            return;
        end
        if ((lex_pend == tll_pkg::PEND_ASSIGN || lex_pend == tll_pkg::PEND_BANG) && b == "=")
        begin
            emit((lex_pend == tll_pkg::PEND_ASSIGN) ? tll_pkg::TK_EQ : tll_pkg::TK_NOT_EQ,
                 lex_begin, 16'd2);
            lex_pend = tll_pkg::PEND_NONE;
            return;
        end
        close_pending();
        lex_start(b, at);
    endfunction

    // tokens caused by one accepted text byte
    function automatic void predict_tokens(input logic [7:0] b, input logic eoi);
        logic [15:0] here;
        if (text_done)
            return;
        here = lex_pos;
        byte_tokens.delete();
        if (b == 8'h00)
        begin
            close_pending();
            emit(tll_pkg::TK_EOF, here, 16'd0);
            text_done = 1'b1;
            lex_pos   = here + 16'd1;
        end
        else
        begin
            lex_continue(b, here);
            lex_pos = here + 16'd1;
            if (eoi)
            begin
                close_pending();
                emit(tll_pkg::TK_EOF, lex_pos, 16'd0);
                text_done = 1'b1;
            end
        end
        if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i])
            tokens_due.push_back(byte_tokens[i]);
    endfunction

    // one text beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(negedge clk);
        end
        text_if.valid        <= 1'b1;
        text_if.in_byte      <= b;
        text_if.end_of_input <= eoi;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        predict_tokens(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        text_if.valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        return "_";
    endfunction

    // one random lexeme, mostly well formed, some noise
    task automatic send_phrase();
        int n;
        case ($urandom_range(0, 11))
            0, 1: send_text(keywords[$urandom_range(0, 6)]);
            2, 3:
            begin
                n = $urandom_range(1, 9);
                repeat (n) send_byte(rand_word_char(), 1'b0);
            end
            4:
            begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
            5, 6: send_byte(single_ops[$urandom_range(0, single_ops.len() - 1)], 1'b0);
            7:
            begin
                if ($urandom_range(0, 1) == 0)
                    send_text("==");
                else
                    send_text("!=");
            end
            8: send_byte(8'($urandom_range(1, 255)), 1'b0);
            default:
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(blanks[$urandom_range(0, 3)], 1'b0);
            end
        endcase
        // a break keeps words apart; often left out
        if ($urandom_range(0, 2) == 0)
            send_byte(" ", 1'b0);
    endtask

    // operators, operator pairs, numbers, blanks and illegal bytes
    task automatic test_single_chars();
        send_text("=x!y==!=;(),+-*/<>{}09_Z \t\r\n");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    // every keyword, one too long and one with the wrong case
    task automatic test_keywords();
        send_text("fn let true false if else return returns iF ");
    endtask

    // an identifier far past the keyword window
    task automatic test_long_token();
        send_idle_pct = 0;
        send_byte("_", 1'b0);
        repeat (LONG_WORD - 1) send_byte("a", 1'b0);
        send_byte(" ", 1'b0);
    endtask

    task automatic test_random_traffic(input int n_bytes, input int send_pct,
                                       input int recv_pct);
        int goal;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal)
            send_phrase();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = HOLD_CYCLES;
        repeat (40) send_byte(stall_ops[$urandom_range(0, stall_ops.len() - 1)], 1'b0);
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct = 26;
        recv_idle_pct = 83;
        repeat (6) send_phrase();
        wait_drained();
        repeat (6) send_phrase();
    endtask

    // close the text, either by a zero byte or by the end mark; later beats are dropped
    task automatic test_end_of_text();
        send_idle_pct = 26;
        recv_idle_pct = 26;
        if ($urandom_range(0, 1) == 0)
        begin
            send_byte("!", 1'b0);
            send_byte(";", 1'b1);
        end
        else
        begin
            send_byte("q", 1'b0);
            send_byte(8'h00, 1'($urandom_range(0, 1)));
        end
        repeat (8) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // token receiver with random stalls and long hold-offs
    initial
    begin : token_sink
        int hold_left;
        hold_left = 0;
        tok_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                tok_if.ready <= 1'b0;
                hold_left--;
            end
            else
                tok_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // compare each token beat with the oldest one due
    always @(posedge clk)
    begin : token_check
        lexed_token_t want;
        if (rst_n && tok_if.valid && tok_if.ready)
        begin
            tokens_checked++;
            if (!kinds_seen[tok_if.token_kind])
            begin
                kinds_seen[tok_if.token_kind] = 1'b1;
                kinds_seen_cnt++;
            end
            if (tokens_due.size() == 0)
                report_mismatch($sformatf("token %0d kind %0d at %0d arrived with none due",
                                          tokens_checked, tok_if.token_kind,
                                          tok_if.token_start));
            else
            begin
                want = tokens_due.pop_front();
                if (tok_if.token_kind !== want.kind)
                    report_mismatch($sformatf("token %0d kind: got %0d, want %0d (%s)",
                                              tokens_checked, tok_if.token_kind, want.kind,
                                              want.kind.name()));
                if (tok_if.token_start !== want.start)
                    report_mismatch($sformatf("token %0d start: got %0d, want %0d",
                                              tokens_checked, tok_if.token_start, want.start));
                if (tok_if.token_length !== want.length)
                    report_mismatch($sformatf("token %0d length: got %0d, want %0d",
                                              tokens_checked, tok_if.token_length,
                                              want.length));
                if (tok_if.last_of_run !== want.last)
                    report_mismatch($sformatf("token %0d last_of_run: got %b, want %b",
                                              tokens_checked, tok_if.last_of_run, want.last));
            end
        end
    end

    // watchdog on cycles where neither channel moves a beat
    always @(posedge clk)
    begin
        if (!rst_n || (text_if.valid && text_if.ready) || (tok_if.valid && tok_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d tokens still due",
                     quiet_cycles, tokens_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : run
        rst_n                = 1'b0;
        text_if.valid        = 1'b0;
        text_if.in_byte      = 8'h00;
        text_if.end_of_input = 1'b0;
        foreach (kw_buf[i])
            kw_buf[i] = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 83;
        test_single_chars();
        test_keywords();
        test_long_token();
        test_random_traffic(30, 26, 83);
        test_random_traffic(30, 83, 26);
        test_random_traffic(30, 0, 0);
        test_backpressure();
        test_pause_until_drained();
        test_end_of_text();

        wait_drained();
        repeat (10) @(posedge clk);

        $display("lexed %0d text bytes into %0d checked tokens, %0d of 27 token kinds seen",
                 bytes_sent, tokens_checked, kinds_seen_cnt);
        $display("covered operator pairs, keywords, a %0d-byte word, a long output stall",
                 LONG_WORD);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
